>>> hdl/pffla_pkg.sv
// Shared types and codes for the page frame free-list allocator.
`default_nettype none

package pffla_pkg;

    // Operation codes carried in the input item's mode field
    localparam logic [1:0] MODE_ADD_REGION = 2'd0;
    localparam logic [1:0] MODE_ALLOCATE   = 2'd1;
    localparam logic [1:0] MODE_FREE       = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_OUT_OF_PAGES = 2'd1;
    localparam logic [1:0] STATUS_BAD_ADDRESS  = 2'd2;

    // Fixed field widths
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 32;
    localparam int COUNT_W = 17;
    localparam int TOTAL_W = 48;
    localparam int FLOOR_W = 17;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // latch the accepted item
        logic setup;      // region add: update total, load walk bounds
        logic push_walk;  // push the frame under the walk cursor
        logic do_op;      // allocate / free / no-op, load result
        logic emit_add;   // load result of a finished region add
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_add;     // latched item is a region add
        logic walk_more;  // cursor still below the region end
        logic out_free;   // result register can take a new item
    } t_dp_sts;

endpackage : pffla_pkg

`default_nettype wire

>>> hdl/pffla_ctrl.sv
// Sequencing state machine for the page frame free-list allocator.
`default_nettype none

module pffla_ctrl
    import pffla_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_add) begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_WALK;
                end else if (i_sts.out_free) begin
                    o_cmd.do_op = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_WALK: begin
                if (i_sts.walk_more) begin
                    o_cmd.push_walk = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_add = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_EXEC))
        else $error("accepted item did not move to execute");

    a_walk_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> i_sts.is_add)
        else $error("region walk on a non-add item");
`endif

endmodule : pffla_ctrl

`default_nettype wire

>>> hdl/pffla_dp.sv
// Datapath: free-list head, link memory, counters and result register.
`default_nettype none

module pffla_dp
    import pffla_pkg::*;
#(
    parameter int NUM_FRAMES = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wen,
    input  wire logic [FLOOR_W-1:0]   i_cfg_wdata,
    input  wire logic [1:0]           i_mode,
    input  wire logic [ADDR_W-1:0]    i_address,
    input  wire logic [LEN_W-1:0]     i_region_length,
    input  wire logic                 i_region_available,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [ADDR_W-1:0]         o_page_address,
    output logic [1:0]                o_status,
    output logic [COUNT_W-1:0]        o_free_page_count,
    output logic [TOTAL_W-1:0]        o_total_memory_bytes
);

    localparam int FW  = $clog2(NUM_FRAMES);       // frame index bits
    localparam int HW  = FW + 1;                   // head incl. empty marker
    localparam int PBW = $clog2(PAGE_BYTES);       // byte offset bits
    localparam int CW  = ((ADDR_W + 1 - PBW) > HW) ? (ADDR_W + 1 - PBW) : HW;
    localparam int PAW = HW + PBW;                 // full page byte address

    localparam logic [HW-1:0] EMPTY_HEAD = HW'(NUM_FRAMES);
    localparam logic [CW-1:0] NF_PG      = CW'(NUM_FRAMES);

    // Latched item
    logic [1:0]        r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic              r_avail;

    logic [FLOOR_W-1:0] r_floor;
    logic [HW-1:0]      r_head, n_head;
    logic [HW-1:0]      r_cnt, n_cnt;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [CW-1:0]      r_cursor, r_last;

    logic [HW-1:0] r_link_mem [NUM_FRAMES];
    logic [HW-1:0] r_link_rd;

    // Result register
    logic              r_ovalid;
    logic [ADDR_W-1:0] r_opage;
    logic [1:0]        r_ostat;
    logic [HW-1:0]     r_ocnt;
    logic [TOTAL_W-1:0] r_ototal;

    // Region bounds in pages
    logic [ADDR_W:0]  ceil_sum, end_sum;
    logic [CW-1:0]    ceil_pg, floor_pg, first_pg, end_pg, last_pg;
    logic [TOTAL_W:0] total_sum;
    logic [CW-1:0]    free_pg;

    // Push / pop / result controls
    logic          push_en;
    logic [FW-1:0] push_frame;
    logic          head_empty;
    logic [PAW-1:0] pop_addr;
    logic          load_out;
    logic [ADDR_W-1:0] n_opage;
    logic [1:0]    n_ostat;

    assign ceil_sum  = (ADDR_W + 1)'(r_addr) + (ADDR_W + 1)'(PAGE_BYTES - 1);
    assign end_sum   = (ADDR_W + 1)'(r_addr) + (ADDR_W + 1)'(r_len);
    assign ceil_pg   = CW'(ceil_sum >> PBW);
    assign end_pg    = CW'(end_sum >> PBW);
    assign floor_pg  = CW'(r_floor);
    assign first_pg  = (ceil_pg > floor_pg) ? ceil_pg : floor_pg;
    assign last_pg   = (end_pg > NF_PG) ? NF_PG : end_pg;
    assign total_sum = (TOTAL_W + 1)'(r_total) + (TOTAL_W + 1)'(r_len);
    assign free_pg   = CW'(r_addr >> PBW);
    assign head_empty = (r_head >= EMPTY_HEAD);
    assign pop_addr  = {r_head, {PBW{1'b0}}};

    always_comb begin
        push_en    = 1'b0;
        push_frame = r_cursor[FW-1:0];
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_total    = r_total;
        n_opage    = '0;
        n_ostat    = STATUS_OK;
        load_out   = i_cmd.emit_add;

        if (i_cmd.setup) begin
            n_total = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        end

        if (i_cmd.push_walk) begin
            push_en = 1'b1;
        end

        if (i_cmd.do_op) begin
            load_out = 1'b1;
            case (r_mode)
                MODE_ALLOCATE: begin
                    if (head_empty) begin
                        n_ostat = STATUS_OUT_OF_PAGES;
                    end else begin
                        n_opage = ADDR_W'(pop_addr);
                        n_head  = r_link_rd;
                        if (r_cnt != '0) begin
                            n_cnt = r_cnt - HW'(1);
                        end
                    end
                end
                MODE_FREE: begin
                    if (free_pg >= NF_PG) begin
                        n_ostat = STATUS_BAD_ADDRESS;
                    end else begin
                        push_en    = 1'b1;
                        push_frame = free_pg[FW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end

        if (push_en) begin
            n_head = HW'(push_frame);
            if (r_cnt < EMPTY_HEAD) begin
                n_cnt = r_cnt + HW'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor  <= '0;
            r_head   <= EMPTY_HEAD;
            r_cnt    <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_floor <= i_cfg_wdata;
            end
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_addr  <= i_address;
            r_len   <= i_region_length;
            r_avail <= i_region_available;
        end
        if (i_cmd.setup) begin
            r_last <= r_avail ? last_pg : '0;
        end
        if (i_cmd.setup) begin
            r_cursor <= first_pg;
        end else if (i_cmd.push_walk) begin
            r_cursor <= r_cursor + CW'(1);
        end
        if (load_out) begin
            r_opage  <= n_opage;
            r_ostat  <= n_ostat;
            r_ocnt   <= n_cnt;
            r_ototal <= n_total;
        end
    end

    // Link memory: one write, one registered read at the head
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_link_mem[push_frame] <= r_head;
        end
        r_link_rd <= r_link_mem[r_head[FW-1:0]];
    end

    assign o_sts.is_add    = (r_mode == MODE_ADD_REGION);
    assign o_sts.walk_more = (r_cursor < r_last);
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid          = r_ovalid;
    assign o_page_address       = r_opage;
    assign o_status             = r_ostat;
    assign o_free_page_count    = COUNT_W'(r_ocnt);
    assign o_total_memory_bytes = r_ototal;

`ifndef SYNTH
    a_walk_sets_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_walk |=> (r_head == HW'($past(r_cursor))))
        else $error("walk push did not move head to cursor frame");

    a_walk_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_walk |-> (r_cursor < r_last && r_cursor < NF_PG))
        else $error("walk push outside region or frame range");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_op || i_cmd.emit_add) |=> r_ovalid)
        else $error("result loaded but not presented");
`endif

endmodule : pffla_dp

`default_nettype wire

>>> hdl/page_frame_free_list_allocator.sv
// Top level of the page frame free-list allocator.
`default_nettype none

// Page frame allocator keeping free frames on a LIFO list: a head register
// names the top frame and a link memory, one entry per frame, names the frame
// below it. Each input item gives exactly one result item. Allocate and free
// are accepted, then run in the execute state using the registered link read
// issued while idle. Region add is accepted, sets its walk bounds, then pushes
// one page per cycle through the single link memory write port before its
// result is loaded. Reserved regions still add to the total and push nothing.
// The link memory needs no clearing pass: an entry is only read after its
// frame was pushed. A new item is taken while the previous result still sits
// in the output register; the result is held back only if that register is
// still full when the next result is ready. The free_floor_page register is
// written through i_cfg_wen / i_cfg_wdata and must only change while idle.
module page_frame_free_list_allocator
    import pffla_pkg::*;
#(
    parameter int NUM_FRAMES = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // free_floor_page register
    input  wire logic         i_cfg_wen,
    input  wire logic [16:0]  i_cfg_wdata,
    // Request items
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,  // [31:0] address, [63:32] region_length
    input  wire logic [2:0]   s_axis_tuser,  // [1:0] mode, [2] region_available
    // Result items
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata,  // [31:0] page_address,
                                             // [48:32] free_page_count,
                                             // [96:49] total_memory_bytes, rest 0
    output logic [1:0]        m_axis_tuser   // [1:0] status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    logic [ADDR_W-1:0]  page_address;
    logic [COUNT_W-1:0] free_page_count;
    logic [TOTAL_W-1:0] total_memory_bytes;

    pffla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pffla_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wen            (i_cfg_wen),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_mode               (s_axis_tuser[1:0]),
        .i_address            (s_axis_tdata[31:0]),
        .i_region_length      (s_axis_tdata[63:32]),
        .i_region_available   (s_axis_tuser[2]),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_out_ready          (m_axis_tready),
        .o_out_valid          (m_axis_tvalid),
        .o_page_address       (page_address),
        .o_status             (m_axis_tuser),
        .o_free_page_count    (free_page_count),
        .o_total_memory_bytes (total_memory_bytes)
    );

    // Pack result fields, low field first, zero pad to whole bytes
    assign m_axis_tdata = {7'd0, total_memory_bytes, free_page_count, page_address};

endmodule : page_frame_free_list_allocator

`default_nettype wire
